FILE: design/brac_pkg.sv
// ----------------------------------------------------------------------------
// brac_pkg
// Shared constants, types and modular arithmetic helpers for the bounded run
// binary array counter.
// ----------------------------------------------------------------------------
package brac_pkg;

  // Results are reduced modulo this prime.
  localparam logic [29:0] PRIME = 30'd1000000007;

  // Residue width.
  localparam int RW = 30;

  // Per-state strobes and flags passed from the sequencer to the datapath.
  typedef struct packed {
    logic cap_a;     // capture the row-above entries from both memories
    logic cap_b;     // capture the run-back entries and form the partial sums
    logic wr;        // write the current entry pair
    logic edge_cell; // current entry lies on a border: its zero or one count is zero
    logic edge0;     // border value for an array starting with a zero
    logic edge1;     // border value for an array starting with a one
    logic sub0;      // zero run may overflow the limit: subtract run-back term
    logic sub1;      // one run may overflow the limit: subtract run-back term
  } ctl_t;

  // (a + b) mod PRIME for residues a and b.
  function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] a,
                                            input logic [RW-1:0] b);
    logic [RW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, PRIME}) begin
      sum = sum - {1'b0, PRIME};
    end
    return sum[RW-1:0];
  endfunction

  // (a - b) mod PRIME for residues a and b.
  function automatic logic [RW-1:0] mod_sub(input logic [RW-1:0] a,
                                            input logic [RW-1:0] b);
    logic [RW:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      diff = diff + {1'b0, PRIME};
    end
    return diff[RW-1:0];
  endfunction

endpackage

FILE: design/brac_ram.sv
// ----------------------------------------------------------------------------
// brac_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brac_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/brac_datapath.sv
// ----------------------------------------------------------------------------
// brac_datapath
// Modular arithmetic for one entry pair: captures memory read data, forms the
// sums of the shorter entries, subtracts the run-back terms and keeps the
// last written pair for the next column and for the final answer.
// ----------------------------------------------------------------------------
module brac_datapath (
  input  logic                      clk,
  input  brac_pkg::ctl_t            ctl,
  input  logic [brac_pkg::RW-1:0]   rdata0,
  input  logic [brac_pkg::RW-1:0]   rdata1,
  output logic [brac_pkg::RW-1:0]   wdata0,
  output logic [brac_pkg::RW-1:0]   wdata1,
  output logic [brac_pkg::RW-1:0]   ans
);

  logic [brac_pkg::RW-1:0] ra0;
  logic [brac_pkg::RW-1:0] ra1;
  logic [brac_pkg::RW-1:0] rb0;
  logic [brac_pkg::RW-1:0] rb1;
  logic [brac_pkg::RW-1:0] s0;
  logic [brac_pkg::RW-1:0] s1;
  logic [brac_pkg::RW-1:0] prev0;
  logic [brac_pkg::RW-1:0] prev1;

  // Entries of the row above, both leading bits.
  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      ra0 <= rdata0;
      ra1 <= rdata1;
    end
  end

  // Run-back terms, zeroed when the run cannot exceed the limit, and the sums
  // of the two shorter entries. The one-led sum uses the previous column.
  always_ff @(posedge clk) begin
    if (ctl.cap_b) begin
      rb0 <= ctl.sub1 ? rdata0 : '0;
      rb1 <= ctl.sub0 ? rdata1 : '0;
      s0  <= brac_pkg::mod_add(ra0, ra1);
      s1  <= brac_pkg::mod_add(prev0, prev1);
    end
  end

  // New entry pair: border values or the corrected sums.
  always_comb begin
    if (ctl.edge_cell) begin
      wdata0 = brac_pkg::RW'(ctl.edge0);
      wdata1 = brac_pkg::RW'(ctl.edge1);
    end else begin
      wdata0 = brac_pkg::mod_sub(s0, rb1);
      wdata1 = brac_pkg::mod_sub(s1, rb0);
    end
  end

  // The last written pair feeds the next column and the answer.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      prev0 <= wdata0;
      prev1 <= wdata1;
    end
  end

  assign ans = brac_pkg::mod_add(prev0, prev1);

endmodule

FILE: design/brac_ctrl.sv
// ----------------------------------------------------------------------------
// brac_ctrl
// Fill sequencer: walks the table row by row, issues the memory reads for each
// interior entry pair, drives the datapath and holds the result register.
// ----------------------------------------------------------------------------
module brac_ctrl #(
  parameter int MAX_COUNT = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,
  input  logic [brac_pkg::RW-1:0]             ans,
  output brac_pkg::ctl_t                      ctl,
  output logic [2*$clog2(MAX_COUNT+1)-1:0]    raddr0,
  output logic [2*$clog2(MAX_COUNT+1)-1:0]    raddr1,
  output logic [2*$clog2(MAX_COUNT+1)-1:0]    waddr
);

  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD_A = 6'b000010,
    S_RD_B = 6'b000100,
    S_SUM  = 6'b001000,
    S_WR   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   z;
  logic [CW-1:0]   o;
  logic [CW-1:0]   zc;
  logic [CW-1:0]   oc;
  logic [7:0]      lim;

  logic [CMPW-1:0] lim_w;
  logic            z_gt;
  logic            o_gt;
  logic [CMPW-1:0] zsub_w;
  logic [CMPW-1:0] osub_w;
  logic [CW-1:0]   z_m1;
  logic [CW-1:0]   o_m1;
  logic            last_col;
  logic            last_row;
  logic [CW-1:0]   z_adv;
  logic [CW-1:0]   o_adv;
  logic            edge_next;
  logic [CW-1:0]   zc_in;
  logic [CW-1:0]   oc_in;
  logic            out_free;

  // Index arithmetic against the run limit.
  always_comb begin
    lim_w    = CMPW'(lim);
    z_gt     = CMPW'(z) > lim_w;
    o_gt     = CMPW'(o) > lim_w;
    zsub_w   = CMPW'(z) - lim_w - CMPW'(1);
    osub_w   = CMPW'(o) - lim_w - CMPW'(1);
    z_m1     = z - CW'(1);
    o_m1     = o - CW'(1);
    last_col = (o == oc);
    last_row = (z == zc);
    if (last_col) begin
      z_adv = z + CW'(1);
      o_adv = '0;
    end else begin
      z_adv = z;
      o_adv = o + CW'(1);
    end
    edge_next = (z_adv == '0) || (o_adv == '0);
  end

  // Counts above the table bound saturate to it.
  always_comb begin
    if (CMPW'(s_tdata[7:0]) > CMPW'(MAX_COUNT)) begin
      zc_in = CW'(MAX_COUNT);
    end else begin
      zc_in = CW'(s_tdata[7:0]);
    end
    if (CMPW'(s_tdata[15:8]) > CMPW'(MAX_COUNT)) begin
      oc_in = CW'(MAX_COUNT);
    end else begin
      oc_in = CW'(s_tdata[15:8]);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Datapath strobes and border values.
  always_comb begin
    ctl.cap_a     = (state == S_RD_B);
    ctl.cap_b     = (state == S_SUM);
    ctl.wr        = (state == S_WR);
    ctl.edge_cell = (z == '0) || (o == '0);
    ctl.edge0     = (z != '0) && !z_gt;
    ctl.edge1     = (z == '0) && !o_gt;
    ctl.sub0      = z_gt;
    ctl.sub1      = o_gt;
  end

  // Row above first, then the entries one run back.
  always_comb begin
    if (state == S_RD_A) begin
      raddr0 = {z_m1, o};
      raddr1 = {z_m1, o};
    end else begin
      raddr0 = {z, osub_w[CW-1:0]};
      raddr1 = {zsub_w[CW-1:0], o};
    end
    waddr = {z, o};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_WR;
        end
      end
      S_RD_A: state_next = S_RD_B;
      S_RD_B: state_next = S_SUM;
      S_SUM:  state_next = S_WR;
      S_WR: begin
        if (last_col && last_row) begin
          state_next = S_DONE;
        end else if (edge_next) begin
          state_next = S_WR;
        end else begin
          state_next = S_RD_A;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and the fill cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      z     <= '0;
      o     <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_tvalid) begin
        z <= '0;
        o <= '0;
      end else if (state == S_WR && !(last_col && last_row)) begin
        z <= z_adv;
        o <= o_adv;
      end
    end
  end

  // Query registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      zc  <= zc_in;
      oc  <= oc_in;
      lim <= s_tdata[23:16];
    end
  end

  // Result register: loaded from the last pair, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {2'b00, ans};
    end
  end

endmodule

FILE: design/bounded_run_binary_array_count.sv
// ----------------------------------------------------------------------------
// bounded_run_binary_array_count
// Counts binary arrays with given numbers of zeros and ones and no run longer
// than a limit, modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage:
//   A query enters on the s_ channel as one transaction carrying the zero
//   count, the one count and the run limit. Counts above MAX_COUNT saturate.
//   The result leaves on the m_ channel as one transaction per query.
//   Each query refills two tables (one per leading bit) row by row. An
//   interior entry pair is read twice on the single read port of each
//   table (row above, then one run back), then its sums are formed and
//   then it is written back. Border entries are written without any reads.
//   One query is worked on at a time; s_tready is high while the sequencer
//   is idle, also while an earlier result still waits in the output
//   register. If that result is not taken when the next one is ready, the
//   sequencer holds until the register frees.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   m_tvalid. The tables need no clearing: every entry a query uses was
//   written earlier in the same query.
// ----------------------------------------------------------------------------
module bounded_run_binary_array_count #(
  parameter int MAX_COUNT = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // zero_count[7:0], one_count[15:8], run_limit[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // array_count[29:0], zero[31:30]
);

  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  brac_pkg::ctl_t          ctl;
  logic [AW-1:0]           raddr0;
  logic [AW-1:0]           raddr1;
  logic [AW-1:0]           waddr;
  logic [brac_pkg::RW-1:0] rdata0;
  logic [brac_pkg::RW-1:0] rdata1;
  logic [brac_pkg::RW-1:0] wdata0;
  logic [brac_pkg::RW-1:0] wdata1;
  logic [brac_pkg::RW-1:0] ans;

  // Sequencer and result register.
  brac_ctrl #(
    .MAX_COUNT (MAX_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ans      (ans),
    .ctl      (ctl),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .waddr    (waddr)
  );

  // Table of arrays that start with a zero.
  brac_ram #(
    .WIDTH (brac_pkg::RW),
    .DEPTH (DEPTH)
  ) u_ram0 (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (waddr),
    .wdata (wdata0),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  // Table of arrays that start with a one.
  brac_ram #(
    .WIDTH (brac_pkg::RW),
    .DEPTH (DEPTH)
  ) u_ram1 (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (waddr),
    .wdata (wdata1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  // Modular arithmetic.
  brac_datapath u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .wdata0 (wdata0),
    .wdata1 (wdata1),
    .ans    (ans)
  );

endmodule

FILE: design/brac_checker.sv
// ----------------------------------------------------------------------------
// brac_checker
// Port-level checks for the bounded run binary array counter, bound to the
// top level.
// ----------------------------------------------------------------------------
module brac_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result transaction holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every result is a reduced residue with zero padding.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:0] < brac_pkg::PRIME) && (m_tdata[31:30] == 2'b00))
    else $error("result not reduced modulo the prime");

  // An accepted query keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("query accepted while a fill was starting");

  // A fresh result appears only as the sequencer returns to idle.
  a_result_ends_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && !$past(s_tready))
    else $error("result appeared outside the end of a fill");

endmodule

bind bounded_run_binary_array_count brac_checker u_checker (.*);

FILE: bench/tb_bounded_run_binary_array_count.sv
// ----------------------------------------------------------------------------
// tb_bounded_run_binary_array_count
// Self-checking bench for the bounded run binary array counter. Queries are
// sent on the s_ stream, and each answer on the m_ stream is compared with a
// count that the bench works out itself by a bottom-up table fill. Directed
// queries cover the border cases and the field extremes. Random queries, with
// random gaps on both sides, a long output stall and a full drain, follow.
// ----------------------------------------------------------------------------
module tb_bounded_run_binary_array_count;

  localparam int          MAX_COUNT    = 255;
  localparam int          DRAIN_CYCLES = 64;
  localparam longint unsigned MODULUS  = 64'd1000000007;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // Answers still owed by the block, oldest first.
  bit [29:0] owed_counts[$];
  int        fail_count  = 0;
  bit        no_gap      = 1'b0;
  int        hold_cycles = 0;

  // Tables of the bench's own fill, one per leading bit.
  bit [29:0] zero_lead [0:MAX_COUNT][0:MAX_COUNT];
  bit [29:0] one_lead  [0:MAX_COUNT][0:MAX_COUNT];

  bounded_run_binary_array_count #(
    .MAX_COUNT(MAX_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // zero_count[7:0], one_count[15:8], run_limit[23:16]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // array_count[29:0], zero[31:30]
  );

  always #4 clk = ~clk;

  // Counts arrays with exactly zc zeros and oc ones and no run above lim.
  function automatic bit [29:0] count_bounded_arrays(input bit [7:0] zc,
                                                     input bit [7:0] oc,
                                                     input bit [7:0] lim);
    longint unsigned acc;
    int z;
    int o;
    for (z = 0; z <= int'(zc); z++) begin
      for (o = 0; o <= int'(oc); o++) begin
        if (z == 0) begin
          zero_lead[z][o] = '0;
          one_lead[z][o]  = 30'(o <= int'(lim));
        end else if (o == 0) begin
          zero_lead[z][o] = 30'(z <= int'(lim));
          one_lead[z][o]  = '0;
        end else begin
          // Arrays opening with a zero run, less those whose run grows too long.
          acc = 64'(zero_lead[z-1][o]) + 64'(one_lead[z-1][o]);
          if (z > int'(lim)) acc += MODULUS - 64'(one_lead[z-int'(lim)-1][o]);
          zero_lead[z][o] = 30'(acc % MODULUS);
          // Arrays opening with a one run, treated the same way.
          acc = 64'(zero_lead[z][o-1]) + 64'(one_lead[z][o-1]);
          if (o > int'(lim)) acc += MODULUS - 64'(zero_lead[z][o-int'(lim)-1]);
          one_lead[z][o] = 30'(acc % MODULUS);
        end
      end
    end
    acc = 64'(zero_lead[zc][oc]) + 64'(one_lead[zc][oc]);
    return 30'(acc % MODULUS);
  endfunction

  // Offers one query after a random gap and waits for its transaction.
  task automatic send_query(input bit [7:0] zc, input bit [7:0] oc,
                            input bit [7:0] lim);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lim, oc, zc};
    do @(posedge clk); while (s_tready !== 1'b1);
    owed_counts.push_back(count_bounded_arrays(zc, oc, lim));
  endtask

  // Drops the input valid once the sender has nothing more to offer.
  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_all_answered();
    while (owed_counts.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls per transaction, and a long one on request.
  initial begin : result_sink
    int        stall;
    bit [29:0] want;
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = no_gap ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
      if (owed_counts.size() == 0) begin
        $error("array_count: no query outstanding, expected none, actual %0d",
               m_tdata[29:0]);
        fail_count++;
      end else begin
        want = owed_counts.pop_front();
        if (m_tdata[29:0] !== want) begin
          $error("array_count mismatch: expected %0d, actual %0d", want, m_tdata[29:0]);
          fail_count++;
        end
        if (m_tdata[31:30] !== 2'b00) begin
          $error("zero padding mismatch: expected 0, actual %0d", m_tdata[31:30]);
          fail_count++;
        end
      end
    end
  end

  // Empty array, a missing kind of element and the zero run limit.
  task automatic test_special_cases();
    send_query(8'd0, 8'd0, 8'd1);
    send_query(8'd0, 8'd0, 8'd0);
    send_query(8'd3, 8'd2, 8'd0);
    send_query(8'd0, 8'd5, 8'd5);
    send_query(8'd0, 8'd6, 8'd5);
    send_query(8'd7, 8'd0, 8'd7);
    send_query(8'd8, 8'd0, 8'd7);
  endtask

  // Largest counts and limits, and the tightest limit of one.
  task automatic test_extreme_counts();
    send_query(8'd255, 8'd0, 8'd255);
    send_query(8'd0, 8'd255, 8'd255);
    send_query(8'd255, 8'd0, 8'd254);
    send_query(8'd255, 8'd2, 8'd255);
    send_query(8'd2, 8'd255, 8'd128);
    send_query(8'd1, 8'd1, 8'd1);
    send_query(8'd10, 8'd10, 8'd1);
    send_query(8'd10, 8'd9, 8'd1);
    send_query(8'd9, 8'd12, 8'd1);
    send_query(8'd16, 8'd16, 8'd2);
    send_query(8'd20, 8'd20, 8'd255);
    send_query(8'd128, 8'd1, 8'd64);
    send_query(8'd255, 8'd255, 8'd3);
  endtask

  // The output stalls for a long stretch while small queries keep coming,
  // so the block holds its result and stops taking input.
  task automatic test_output_backpressure();
    hold_cycles = 400;
    repeat (6) send_query(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(1, 3)));
  endtask

  // The sender goes quiet until every answer is in, then starts again.
  task automatic test_sender_pause();
    release_input();
    wait_all_answered();
    repeat (3) send_query(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                          8'($urandom_range(1, 6)));
  endtask

  // Mostly small counts with tight limits; a few wider ones and wide limits.
  task automatic test_random_queries();
    bit [7:0] zc;
    bit [7:0] oc;
    bit [7:0] lim;
    int       pick;
    for (int i = 0; i < 80; i++) begin
      if (i % 10 == 0) no_gap = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        zc = 8'($urandom_range(0, 40));
        oc = 8'($urandom_range(0, 40));
      end else begin
        zc = 8'($urandom_range(0, 12));
        oc = 8'($urandom_range(0, 12));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) lim = 8'($urandom_range(1, 4));
      else if (pick < 8) lim = 8'($urandom_range(1, 12));
      else lim = 8'($urandom_range(1, 255));
      send_query(zc, oc, lim);
    end
    no_gap = 1'b0;
  endtask

  initial begin : test_sequence
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_extreme_counts();
    test_output_backpressure();
    test_sender_pause();
    test_random_queries();
    release_input();
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung block: far beyond the slowest correct run.
  initial begin : watchdog
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
